// File: hw/rtl/sbmd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SAD block matching package
// Shared constants, beat types, state codes and cell controls.
// ----------------------------------------------------------------------------
package sbmd_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_DISP    = 63;
    localparam int MAX_BLOCK   = 15;
    localparam int NUM_CELLS   = MAX_DISP + 1;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int SLOT_W      = $clog2(MAX_BLOCK);
    localparam int ADDR_W      = SLOT_W + COL_W;
    localparam int STORE_DEPTH = MAX_BLOCK * MAX_WIDTH;
    localparam int SUM_W       = 16;

    localparam logic [7:0] CFG_WIDTH  = 8'd0;
    localparam logic [7:0] CFG_HEIGHT = 8'd1;
    localparam logic [7:0] CFG_DISP   = 8'd2;
    localparam logic [7:0] CFG_HALF   = 8'd3;

    typedef struct packed {
        logic [7:0] left_pixel;
        logic [7:0] right_pixel;
        logic       frame_start;
    } t_in_beat;

    typedef struct packed {
        logic             out_valid;
        logic [5:0]       disparity;
        logic [SUM_W-1:0] best_cost;
        logic             frame_end;
    } t_out_beat;

    typedef struct packed {
        logic shift;
        logic acc;
        logic clear;
        logic scan;
    } t_cell_ctrl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_DECIDE,
        ST_ROWS,
        ST_DRAIN,
        ST_SCAN,
        ST_FINISH
    } t_state;

endpackage
`default_nettype wire

// File: hw/rtl/sbmd_line_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SAD block matching line store
// Ring of image rows for the left and right pixels, one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
module sbmd_line_store (
    input  wire logic                        i_clk,
    input  wire logic                        i_wr_en,
    input  wire logic [sbmd_pkg::ADDR_W-1:0] i_wr_addr,
    input  wire logic [7:0]                  i_wr_left,
    input  wire logic [7:0]                  i_wr_right,
    input  wire logic [sbmd_pkg::ADDR_W-1:0] i_rd_addr,
    output logic      [7:0]                  o_rd_left,
    output logic      [7:0]                  o_rd_right
);
    import sbmd_pkg::*;

    logic [7:0] r_left_mem  [STORE_DEPTH];
    logic [7:0] r_right_mem [STORE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_left_mem[i_wr_addr]  <= i_wr_left;
            r_right_mem[i_wr_addr] <= i_wr_right;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_left  <= r_left_mem[i_rd_addr];
        o_rd_right <= r_right_mem[i_rd_addr];
    end

endmodule
`default_nettype wire

// File: hw/rtl/sbmd_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SAD block matching disparity cell
// Holds one delayed right pixel and the window sum of one disparity.
// ----------------------------------------------------------------------------
module sbmd_cell (
    input  wire logic                       i_clk,
    input  wire sbmd_pkg::t_cell_ctrl       i_ctrl,
    input  wire logic [7:0]                 i_left,
    input  wire logic [7:0]                 i_right,
    output logic      [7:0]                 o_right,
    input  wire logic [sbmd_pkg::SUM_W-1:0] i_sum_next,
    output logic      [sbmd_pkg::SUM_W-1:0] o_sum
);
    import sbmd_pkg::*;

    logic [7:0]       r_right;
    logic [SUM_W-1:0] r_sum;
    logic [7:0]       diff;

    assign diff = (i_left > i_right) ? (i_left - i_right) : (i_right - i_left);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_right <= i_right;
        end
        if (i_ctrl.clear) begin
            r_sum <= '0;
        end else if (i_ctrl.scan) begin
            r_sum <= i_sum_next;
        end else if (i_ctrl.acc) begin
            r_sum <= r_sum + {{(SUM_W-8){1'b0}}, diff};
        end
    end

    assign o_right = r_right;
    assign o_sum   = r_sum;

endmodule
`default_nettype wire

// File: hw/rtl/sbmd_chain.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SAD block matching cell chain
// Row of disparity cells; right pixels move up the row, sums move down it.
// ----------------------------------------------------------------------------
module sbmd_chain (
    input  wire logic                       i_clk,
    input  wire sbmd_pkg::t_cell_ctrl       i_ctrl,
    input  wire logic [7:0]                 i_left,
    input  wire logic [7:0]                 i_right,
    output logic      [sbmd_pkg::SUM_W-1:0] o_head_sum
);
    import sbmd_pkg::*;

    logic [7:0]       w_right [NUM_CELLS];
    logic [SUM_W-1:0] w_sum   [NUM_CELLS+1];

    assign w_right[0]         = i_right;
    assign w_sum[NUM_CELLS]   = '0;
    assign o_head_sum         = w_sum[0];

    for (genvar d = 0; d < NUM_CELLS; d++) begin : g_cell
        if (d < NUM_CELLS - 1) begin : g_mid
            sbmd_cell u_cell (
                .i_clk      (i_clk),
                .i_ctrl     (i_ctrl),
                .i_left     (i_left),
                .i_right    (w_right[d]),
                .o_right    (w_right[d+1]),
                .i_sum_next (w_sum[d+1]),
                .o_sum      (w_sum[d])
            );
        end else begin : g_last
            sbmd_cell u_cell (
                .i_clk      (i_clk),
                .i_ctrl     (i_ctrl),
                .i_left     (i_left),
                .i_right    (w_right[d]),
                .o_right    (),
                .i_sum_next (w_sum[d+1]),
                .o_sum      (w_sum[d])
            );
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/sad_block_match_disparity_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SAD block matching stereo disparity
// Raster pixel pairs in, one delayed disparity result out per pixel.
// ----------------------------------------------------------------------------
// One pixel pair is taken at a time. A pixel whose delayed result lies on the
// border or in the unfilled delay goes from the decide state straight to the
// finish state. For an interior result each of the 2h+1 window rows is
// streamed out of the line store one column per cycle through a row of 64
// disparity cells, and the winner is then found by shifting the cell sums
// past one comparator. The line store needs no clearing after reset. A
// finished result waits in the output register while the next pixel is
// taken.
module sad_block_match_disparity_top (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire sbmd_pkg::t_in_beat  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output sbmd_pkg::t_out_beat      o_out_data,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [7:0]          i_cfg_index,
    input  wire logic [10:0]         i_cfg_data
);
    import sbmd_pkg::*;

    // configuration
    logic [10:0] r_cfg_width, r_cfg_height;
    logic [5:0]  r_cfg_disp;
    logic [2:0]  r_cfg_half;
    logic [10:0] w, hgt;
    logic [5:0]  md;
    logic [2:0]  h;

    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= 11'd1024;
            r_cfg_height <= 11'd1024;
            r_cfg_disp   <= 6'd63;
            r_cfg_half   <= 3'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WIDTH:  r_cfg_width  <= i_cfg_data;
                CFG_HEIGHT: r_cfg_height <= i_cfg_data;
                CFG_DISP:   r_cfg_disp   <= i_cfg_data[5:0];
                CFG_HALF:   r_cfg_half   <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    assign w   = (r_cfg_width < 11'd3) ? 11'd3 :
                 (r_cfg_width > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : r_cfg_width;
    assign hgt = (r_cfg_height < 11'd3) ? 11'd3 :
                 (r_cfg_height > 11'd1024) ? 11'd1024 : r_cfg_height;
    assign md  = r_cfg_disp;
    assign h   = r_cfg_half;

    // state
    t_state r_state, n_state;
    logic [COL_W-1:0]  r_col, r_row, r_cur_col, r_cur_row;
    logic [SLOT_W-1:0] r_slot, r_cur_slot, r_win_slot;
    logic [20:0]       r_n;
    logic [13:0]       r_delay;
    logic [3:0]        r_row_cnt;
    logic [6:0]        r_step;
    logic [COL_W-1:0]  r_base_col;
    logic [5:0]        r_scan_d;
    logic [5:0]        r_best_d;
    logic [SUM_W-1:0]  r_best_sum;
    logic              r_rd_vld, r_rd_acc;
    t_out_beat         r_res, r_out;
    logic              r_out_full;
    logic              r_fend;
    logic [SUM_W-1:0]  head_sum;

    logic in_acc, out_load, last_step, last_row;
    t_cell_ctrl ctrl;

    assign in_acc     = i_in_valid && o_in_ready;
    assign out_load   = (r_state == ST_FINISH) && (!r_out_full || i_out_ready);
    assign last_step  = r_step == 7'({1'b0, md} + {3'b0, h, 1'b0});
    assign last_row   = r_row_cnt == {h, 1'b0};

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(MAX_BLOCK - 1)) ? '0 : s + 1'b1;
    endfunction

    // position of the arriving pixel and of the next one
    logic [10:0] col0, row0, coln, rown;
    logic [SLOT_W-1:0] slot0, slotn;

    always_comb begin
        col0  = i_in_data.frame_start ? 11'd0 : {1'b0, r_col};
        row0  = i_in_data.frame_start ? 11'd0 : {1'b0, r_row};
        slot0 = i_in_data.frame_start ? '0 : r_slot;
        if (col0 >= w) begin
            col0  = 11'd0;
            row0  = row0 + 11'd1;
            slot0 = slot_inc(slot0);
        end
        if (row0 >= hgt) begin
            row0  = 11'd0;
            slot0 = '0;
        end
        coln  = col0 + 11'd1;
        rown  = row0;
        slotn = slot0;
        if (coln >= w) begin
            coln  = 11'd0;
            rown  = row0 + 11'd1;
            slotn = slot_inc(slot0);
            if (rown >= hgt) begin
                rown  = 11'd0;
                slotn = '0;
            end
        end
    end

    // where the delayed result pixel sits
    logic        res_valid, col_ge_h, interior;
    logic [11:0] ox, oy, base_full;
    logic [4:0]  top_raw;
    logic [SLOT_W-1:0] top_slot;

    always_comb begin
        res_valid = {7'd0, r_delay} <= r_n;
        col_ge_h  = {1'b0, r_cur_col} >= {8'd0, h};
        ox = col_ge_h ? ({2'b0, r_cur_col} - {9'd0, h})
                      : ({2'b0, r_cur_col} + {1'b0, w} - {9'd0, h});
        oy = col_ge_h ? ({2'b0, r_cur_row} - {9'd0, h})
                      : ({2'b0, r_cur_row} - {9'd0, h} - 12'd1);
        interior = res_valid && (w > {8'd0, h}) && (oy >= {9'd0, h})
                && (oy + {9'd0, h} < {1'b0, hgt})
                && (ox >= {6'd0, md} + {9'd0, h})
                && (ox + {9'd0, h} < {1'b0, w});
        base_full = ox - {9'd0, h} - {6'd0, md};
        top_raw = {1'b0, r_cur_slot} + 5'(MAX_BLOCK) - {1'b0, h, 1'b0}
                - {4'd0, !col_ge_h};
        top_slot = (top_raw >= 5'(MAX_BLOCK)) ? SLOT_W'(top_raw - 5'(MAX_BLOCK))
                                               : top_raw[SLOT_W-1:0];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (in_acc) n_state = ST_CALC;
            ST_CALC:   n_state = ST_DECIDE;
            ST_DECIDE: n_state = interior ? ST_ROWS : ST_FINISH;
            ST_ROWS:   if (last_step && last_row) n_state = ST_DRAIN;
            ST_DRAIN:  n_state = ST_SCAN;
            ST_SCAN:   if (r_scan_d == md) n_state = ST_FINISH;
            ST_FINISH: if (out_load) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_in_ready = (r_state == ST_IDLE) && i_rst_n;
        ctrl.shift = r_rd_vld;
        ctrl.acc   = r_rd_acc;
        ctrl.clear = r_state == ST_DECIDE;
        ctrl.scan  = r_state == ST_SCAN;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_col    <= '0;
            r_row    <= '0;
            r_slot   <= '0;
            r_rd_vld <= 1'b0;
            r_rd_acc <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= r_state == ST_ROWS;
            r_rd_acc <= (r_state == ST_ROWS) && (r_step >= {1'b0, md});
            if (in_acc) begin
                r_col  <= coln[COL_W-1:0];
                r_row  <= rown[COL_W-1:0];
                r_slot <= slotn;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cur_col  <= col0[COL_W-1:0];
            r_cur_row  <= row0[COL_W-1:0];
            r_cur_slot <= slot0;
        end
        if (r_state == ST_CALC) begin
            r_n     <= 21'(r_cur_row * w) + {11'd0, r_cur_col};
            r_delay <= 14'(h * w) + {11'd0, h};
            r_fend  <= ({1'b0, r_cur_col} == w - 11'd1)
                    && ({1'b0, r_cur_row} == hgt - 11'd1);
        end
        if (r_state == ST_DECIDE) begin
            r_res.out_valid <= res_valid;
            r_res.disparity <= '0;
            r_res.best_cost <= '0;
            r_res.frame_end <= res_valid && r_fend;
            r_win_slot <= top_slot;
            r_base_col <= base_full[COL_W-1:0];
            r_row_cnt  <= '0;
            r_step     <= '0;
            r_scan_d   <= '0;
        end
        if (r_state == ST_ROWS) begin
            if (last_step) begin
                r_step     <= '0;
                r_row_cnt  <= r_row_cnt + 4'd1;
                r_win_slot <= slot_inc(r_win_slot);
            end else begin
                r_step <= r_step + 7'd1;
            end
        end
        if (r_state == ST_SCAN) begin
            // Ties keep the smaller disparity.
            if (r_scan_d == 6'd0 || head_sum < r_best_sum) begin
                r_best_sum <= head_sum;
                r_best_d   <= r_scan_d;
            end
            r_scan_d <= r_scan_d + 6'd1;
        end
        if (r_state == ST_SCAN && r_scan_d == md) begin
            if (r_scan_d == 6'd0 || head_sum < r_best_sum) begin
                r_res.disparity <= r_scan_d;
                r_res.best_cost <= head_sum;
            end else begin
                r_res.disparity <= r_best_d;
                r_res.best_cost <= r_best_sum;
            end
        end
        if (out_load) begin
            r_out <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_full <= 1'b0;
        end else if (out_load) begin
            r_out_full <= 1'b1;
        end else if (i_out_ready) begin
            r_out_full <= 1'b0;
        end
    end

    assign o_out_valid = r_out_full;
    assign o_out_data  = r_out;

    // datapath
    logic [7:0]       rd_left, rd_right;
    logic [COL_W-1:0] rd_col;

    assign rd_col = r_base_col + COL_W'(r_step);

    sbmd_line_store u_store (
        .i_clk      (i_clk),
        .i_wr_en    (in_acc),
        .i_wr_addr  ({slot0, col0[COL_W-1:0]}),
        .i_wr_left  (i_in_data.left_pixel),
        .i_wr_right (i_in_data.right_pixel),
        .i_rd_addr  ({r_win_slot, rd_col}),
        .o_rd_left  (rd_left),
        .o_rd_right (rd_right)
    );

    sbmd_chain u_chain (
        .i_clk      (i_clk),
        .i_ctrl     (ctrl),
        .i_left     (rd_left),
        .i_right    (rd_right),
        .o_head_sum (head_sum)
    );

`ifndef ASSERT_OFF
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state == ST_CALC)
        else $error("accepted beat did not start processing");
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_scan_d <= md))
        else $error("scan ran past the largest disparity");
    a_acc_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_acc |-> r_rd_vld)
        else $error("accumulate without read data");
    a_load_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_out_full && r_state == ST_IDLE))
        else $error("result load did not fill the output register");
`endif

endmodule
`default_nettype wire
